@@ rtl/lfu_pkg.sv @@
// Shared types and constants for the LFU cache table.
`timescale 1ns / 1ps

package lfu_pkg;

	// Field widths fixed by the request and result formats.
	localparam int unsigned KEY_W = 32;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned CAP_W = 5;

	// Capacity register value after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Request type codes.
	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;     // capture the request and restart the scan
		logic ptr_clear;  // restart the entry pointer for the rank pass
		logic scan;       // lookup and victim search pass
		logic rank;       // recency rank update pass
		logic commit;     // write the target entry and load the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pass_done;  // every entry of the current pass has been handled
		logic need_rank;  // the request touches an entry, so ranks move
		logic out_free;   // the result register can take a new result
	} sts_t;

endpackage

@@ rtl/lfu_dp.sv @@
// Datapath of the LFU cache table: entry memories, scan logic and result register.
`timescale 1ns / 1ps

module lfu_dp #(
	parameter int unsigned ENTRIES    = 16,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]            cfg_wdata,
	input  logic                                 req_type,
	input  logic signed [lfu_pkg::KEY_W-1:0]     key,
	input  logic signed [lfu_pkg::VAL_W-1:0]     value,
	input  lfu_pkg::cmd_t                        cmd,
	output lfu_pkg::sts_t                        sts,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 found,
	output logic signed [lfu_pkg::VAL_W-1:0]     read_value,
	output logic                                 evicted,
	output logic signed [lfu_pkg::KEY_W-1:0]     evicted_key
);

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned PTR_W = $clog2(ENTRIES + 1);
	localparam int unsigned CMP_W = (PTR_W > lfu_pkg::CAP_W) ? PTR_W : lfu_pkg::CAP_W;
	localparam logic [PTR_W-1:0] PTR_END = PTR_W'(ENTRIES);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Entry storage.
	logic [ENTRIES-1:0]             valid_q;
	logic [lfu_pkg::KEY_W-1:0]      key_mem   [ENTRIES];
	logic [lfu_pkg::VAL_W-1:0]      value_mem [ENTRIES];
	logic [COUNT_BITS-1:0]          cnt_mem   [ENTRIES];
	logic [IDX_W-1:0]               rank_mem  [ENTRIES];
	logic [PTR_W-1:0]               occ_q;
	logic [lfu_pkg::CAP_W-1:0]      cap_q;

	// Captured request.
	logic                           put_q;
	logic [lfu_pkg::KEY_W-1:0]      req_key_q;
	logic [lfu_pkg::VAL_W-1:0]      req_value_q;

	// Scan pointer and registered read stage.
	logic [PTR_W-1:0]               ptr_q;
	logic [IDX_W-1:0]               rd_addr;
	logic                           issue;
	logic                           live_scan_s1;
	logic                           live_rank_s1;
	logic                           valid_s1;
	logic [IDX_W-1:0]               idx_s1;
	logic [lfu_pkg::KEY_W-1:0]      key_s1;
	logic [lfu_pkg::VAL_W-1:0]      value_s1;
	logic [COUNT_BITS-1:0]          cnt_s1;
	logic [IDX_W-1:0]               rank_s1;

	// Scan findings.
	logic                           hit_found_q;
	logic [IDX_W-1:0]               hit_idx_q;
	logic [IDX_W-1:0]               hit_rank_q;
	logic [COUNT_BITS-1:0]          hit_cnt_q;
	logic [lfu_pkg::VAL_W-1:0]      hit_val_q;
	logic                           vic_found_q;
	logic [IDX_W-1:0]               vic_idx_q;
	logic [IDX_W-1:0]               vic_rank_q;
	logic [COUNT_BITS-1:0]          vic_cnt_q;
	logic [lfu_pkg::KEY_W-1:0]      vic_key_q;
	logic                           free_found_q;
	logic [IDX_W-1:0]               free_idx_q;

	// Decision and update values.
	logic                           key_match;
	logic                           take_hit;
	logic                           take_vic;
	logic                           take_free;
	logic [CMP_W-1:0]               cap_eff;
	logic                           do_insert;
	logic                           do_evict;
	logic [IDX_W-1:0]               slot;
	logic [COUNT_BITS-1:0]          cnt_next;
	logic [IDX_W-1:0]               rank_new;
	logic                           rank_wr;

	// Result register.
	logic                           res_valid_q;
	logic                           found_q;
	logic [lfu_pkg::VAL_W-1:0]      read_value_q;
	logic                           evicted_q;
	logic [lfu_pkg::KEY_W-1:0]      evicted_key_q;

	// Effective capacity and the decision taken once the scan is complete.
	always_comb begin
		if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end else begin
			cap_eff = CMP_W'(cap_q);
		end
		do_insert = !hit_found_q && put_q && (cap_eff != '0);
		do_evict  = do_insert && (CMP_W'(occ_q) >= cap_eff);
		if (hit_found_q) begin
			slot = hit_idx_q;
		end else if (do_evict) begin
			slot = vic_idx_q;
		end else begin
			slot = free_idx_q;
		end
		cnt_next = (hit_cnt_q == COUNT_MAX) ? hit_cnt_q : hit_cnt_q + COUNT_BITS'(1);
	end

	// New recency rank of a valid entry other than the touched one.
	always_comb begin
		if (hit_found_q) begin
			rank_new = (rank_s1 < hit_rank_q) ? rank_s1 + IDX_W'(1) : rank_s1;
		end else if (do_evict) begin
			rank_new = (rank_s1 > vic_rank_q) ? rank_s1 : rank_s1 + IDX_W'(1);
		end else begin
			rank_new = rank_s1 + IDX_W'(1);
		end
		rank_wr = live_rank_s1 && valid_s1 && (idx_s1 != slot);
	end

	// Comparisons for the entry that is in the read stage.
	always_comb begin
		key_match = live_scan_s1 && valid_s1 && !hit_found_q && (key_s1 == req_key_q);
		take_vic  = live_scan_s1 && valid_s1 && (!vic_found_q || (cnt_s1 < vic_cnt_q) ||
		            ((cnt_s1 == vic_cnt_q) && (rank_s1 > vic_rank_q)));
		take_free = live_scan_s1 && !valid_s1 && !free_found_q;
		take_hit  = key_match;
	end

	assign rd_addr = ptr_q[IDX_W-1:0];
	assign issue   = (cmd.scan || cmd.rank) && (ptr_q != PTR_END);

	// Status to the controller.
	always_comb begin
		sts.pass_done = (ptr_q == PTR_END) && !live_scan_s1 && !live_rank_s1;
		sts.need_rank = hit_found_q || do_insert;
		sts.out_free  = !res_valid_q || !out_stall;
	end

	// Control state: pointer, read stage flags, findings flags, occupancy, valid bits, capacity, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			live_scan_s1 <= 1'b0;
			live_rank_s1 <= 1'b0;
			hit_found_q  <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			occ_q        <= '0;
			valid_q      <= '0;
			cap_q        <= lfu_pkg::CAP_RESET;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.accept || cmd.ptr_clear) begin
				ptr_q <= '0;
			end else if (issue) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
			live_scan_s1 <= issue && cmd.scan;
			live_rank_s1 <= issue && cmd.rank;
			if (cmd.accept) begin
				hit_found_q  <= 1'b0;
				vic_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (take_hit) begin
					hit_found_q <= 1'b1;
				end
				if (take_vic) begin
					vic_found_q <= 1'b1;
				end
				if (take_free) begin
					free_found_q <= 1'b1;
				end
			end
			if (cmd.commit && do_insert) begin
				valid_q[slot] <= 1'b1;
				if (!do_evict) begin
					occ_q <= occ_q + PTR_W'(1);
				end
			end
			if (cmd.commit) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, read stage and findings payload.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			put_q       <= (req_type == lfu_pkg::REQ_PUT);
			req_key_q   <= key;
			req_value_q <= value;
		end
		valid_s1 <= valid_q[rd_addr];
		idx_s1   <= rd_addr;
		if (take_hit) begin
			hit_idx_q  <= idx_s1;
			hit_rank_q <= rank_s1;
			hit_cnt_q  <= cnt_s1;
			hit_val_q  <= value_s1;
		end
		if (take_vic) begin
			vic_idx_q  <= idx_s1;
			vic_rank_q <= rank_s1;
			vic_cnt_q  <= cnt_s1;
			vic_key_q  <= key_s1;
		end
		if (take_free) begin
			free_idx_q <= idx_s1;
		end
	end

	// Key memory.
	always_ff @(posedge clk) begin
		if (cmd.commit && do_insert) begin
			key_mem[slot] <= req_key_q;
		end
		key_s1 <= key_mem[rd_addr];
	end

	// Value memory.
	always_ff @(posedge clk) begin
		if (cmd.commit && (do_insert || (hit_found_q && put_q))) begin
			value_mem[slot] <= req_value_q;
		end
		value_s1 <= value_mem[rd_addr];
	end

	// Use count memory.
	always_ff @(posedge clk) begin
		if (cmd.commit && (do_insert || hit_found_q)) begin
			cnt_mem[slot] <= hit_found_q ? cnt_next : COUNT_BITS'(1);
		end
		cnt_s1 <= cnt_mem[rd_addr];
	end

	// Recency rank memory: shifted during the rank pass, zeroed for the touched entry.
	always_ff @(posedge clk) begin
		if (cmd.commit && (do_insert || hit_found_q)) begin
			rank_mem[slot] <= '0;
		end else if (rank_wr) begin
			rank_mem[idx_s1] <= rank_new;
		end
		rank_s1 <= rank_mem[rd_addr];
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			found_q       <= hit_found_q;
			read_value_q  <= (hit_found_q && !put_q) ? hit_val_q : '0;
			evicted_q     <= do_evict;
			evicted_key_q <= do_evict ? vic_key_q : '0;
		end
	end

	assign out_valid   = res_valid_q;
	assign found       = found_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule

@@ rtl/lfu_ctrl.sv @@
// Controller state machine of the LFU cache table.
`timescale 1ns / 1ps

module lfu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  lfu_pkg::sts_t  sts,
	output lfu_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RANK,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   stall_q;

	// Command decode from the current state.
	always_comb begin
		cmd           = '0;
		cmd.accept    = (state_q == ST_IDLE) && in_valid;
		cmd.scan      = (state_q == ST_SCAN);
		cmd.ptr_clear = (state_q == ST_SCAN) && sts.pass_done;
		cmd.rank      = (state_q == ST_RANK);
		cmd.commit    = (state_q == ST_COMMIT) && sts.out_free;
	end

	// State and the registered request stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
						stall_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (sts.pass_done) begin
						state_q <= sts.need_rank ? ST_RANK : ST_COMMIT;
					end
				end
				ST_RANK: begin
					if (sts.pass_done) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_stall = stall_q;

endmodule

@@ rtl/lfu_cache_table_top.sv @@
// Top level of the LFU cache table with LRU tie break.
//
//   channel   direction  handshake           payload
//   cfg       in         cfg_we              cfg_wdata (capacity in use)
//   request   in         in_valid/in_stall   req_type, key, value
//   result    out        out_valid/out_stall found, read_value, evicted, evicted_key
//
// A request makes one sequential pass over the entry memories for lookup and victim search;
// when an entry is touched (any request but a miss that stores nothing), a second pass
// rewrites the recency ranks.
// Reset clears all valid bits and the occupancy at once; no clearing pass is run.
// A finished result waits in the output register while out_stall is high; the next
// request is taken meanwhile and holds in its last step until the register frees.
`timescale 1ns / 1ps

module lfu_cache_table_top #(
	parameter int unsigned ENTRIES    = 16,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]         cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic signed [lfu_pkg::KEY_W-1:0]  key,
	input  logic signed [lfu_pkg::VAL_W-1:0]  value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic signed [lfu_pkg::VAL_W-1:0]  read_value,
	output logic                              evicted,
	output logic signed [lfu_pkg::KEY_W-1:0]  evicted_key
);

	lfu_pkg::cmd_t cmd;
	lfu_pkg::sts_t sts;

	// Sequencer.
	lfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Entry storage and result register.
	lfu_dp #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req_type    (req_type),
		.key         (key),
		.value       (value),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

endmodule

@@ dv/tb_lfu_cache_table_top.sv @@
// Self-checking testbench for the LFU cache table: shadow cache model and bursty traffic.
`timescale 1ns / 1ps

module tb_lfu_cache_table_top;

	// A narrow use count lets saturation show up within a short run.
	localparam int unsigned ENTRIES     = 16;
	localparam int unsigned COUNT_BITS  = 4;
	localparam int unsigned COUNT_MAX   = (1 << COUNT_BITS) - 1;
	localparam int unsigned SETTLE      = 2 * ENTRIES + 8;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned POOL_SIZE   = 20;
	localparam int unsigned PHASE_REQS  = 150;

	typedef struct packed {
		logic                              req_type;
		logic signed [lfu_pkg::KEY_W-1:0]  key;
		logic signed [lfu_pkg::VAL_W-1:0]  value;
	} cache_req_t;

	typedef struct packed {
		logic                              found;
		logic signed [lfu_pkg::VAL_W-1:0]  read_value;
		logic                              evicted;
		logic signed [lfu_pkg::KEY_W-1:0]  evicted_key;
	} cache_resp_t;

	// Shadow copy of the cache and the queue of responses still due from the block.
	class cache_scoreboard;
		logic [lfu_pkg::CAP_W-1:0]   capacity;
		bit                          valid [ENTRIES];
		logic [lfu_pkg::KEY_W-1:0]   keys [ENTRIES];
		logic [lfu_pkg::VAL_W-1:0]   vals [ENTRIES];
		int unsigned                 uses [ENTRIES];
		int unsigned                 rank [ENTRIES];
		int unsigned                 occupied;
		cache_resp_t                 due_responses [$];
		int unsigned                 mismatches;

		function new();
			capacity = lfu_pkg::CAP_RESET;
			occupied = 0;
			mismatches = 0;
			foreach (valid[j]) begin
				valid[j] = 1'b0;
			end
		endfunction

		task report(input string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		// Move an entry to the front of the recency order.
		function void promote(int idx);
			int unsigned prior;
			prior = rank[idx];
			for (int j = 0; j < ENTRIES; j++) begin
				if (valid[j] && j != idx && rank[j] < prior) begin
					rank[j]++;
				end
			end
			rank[idx] = 0;
		endfunction

		// Lowest use count, and among equal counts the least recently accessed.
		function int victim_slot();
			int best;
			best = -1;
			for (int j = 0; j < ENTRIES; j++) begin
				if (valid[j] && (best < 0 || uses[j] < uses[best] ||
						(uses[j] == uses[best] && rank[j] > rank[best]))) begin
					best = j;
				end
			end
			return best;
		endfunction

		function void drop(int idx);
			for (int j = 0; j < ENTRIES; j++) begin
				if (valid[j] && j != idx && rank[j] > rank[idx]) begin
					rank[j]--;
				end
			end
			valid[idx] = 1'b0;
			occupied--;
		endfunction

		// Apply one accepted request to the shadow cache and queue its response.
		function void apply_request(cache_req_t r);
			cache_resp_t resp;
			int          hit;
			int          slot;
			int unsigned cap;
			resp = '0;
			hit = -1;
			slot = -1;
			cap = (capacity > ENTRIES) ? ENTRIES : capacity;
			for (int j = 0; j < ENTRIES; j++) begin
				if (hit < 0 && valid[j] && keys[j] == r.key) begin
					hit = j;
				end
			end
			if (hit >= 0) begin
				resp.found = 1'b1;
				if (uses[hit] < COUNT_MAX) begin
					uses[hit]++;
				end
				promote(hit);
				if (r.req_type == lfu_pkg::REQ_PUT) begin
					vals[hit] = r.value;
				end else begin
					resp.read_value = vals[hit];
				end
			end else if (r.req_type == lfu_pkg::REQ_PUT && cap > 0) begin
				if (occupied >= cap) begin
					slot = victim_slot();
					resp.evicted = 1'b1;
					resp.evicted_key = keys[slot];
					drop(slot);
				end else begin
					for (int j = ENTRIES - 1; j >= 0; j--) begin
						if (!valid[j]) begin
							slot = j;
						end
					end
				end
				for (int j = 0; j < ENTRIES; j++) begin
					if (valid[j]) begin
						rank[j]++;
					end
				end
				valid[slot] = 1'b1;
				keys[slot] = r.key;
				vals[slot] = r.value;
				uses[slot] = 1;
				rank[slot] = 0;
				occupied++;
			end
			due_responses.push_back(resp);
		endfunction

		// Compare one response from the block with the oldest one due.
		task check_response(input cache_resp_t got);
			cache_resp_t want;
			if (due_responses.size() == 0) begin
				report("response with no request outstanding");
			end else begin
				want = due_responses.pop_front();
				if (got.found !== want.found) begin
					report($sformatf("found %b, expected %b", got.found, want.found));
				end
				if (got.read_value !== want.read_value) begin
					report($sformatf("read_value %h, expected %h",
						got.read_value, want.read_value));
				end
				if (got.evicted !== want.evicted) begin
					report($sformatf("evicted %b, expected %b", got.evicted, want.evicted));
				end
				if (got.evicted_key !== want.evicted_key) begin
					report($sformatf("evicted_key %h, expected %h",
						got.evicted_key, want.evicted_key));
				end
			end
		endtask
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              cfg_we;
	logic [lfu_pkg::CAP_W-1:0]         cfg_wdata;
	logic                              in_valid;
	logic                              in_stall;
	logic                              req_type;
	logic signed [lfu_pkg::KEY_W-1:0]  key;
	logic signed [lfu_pkg::VAL_W-1:0]  value;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic                              found;
	logic signed [lfu_pkg::VAL_W-1:0]  read_value;
	logic                              evicted;
	logic signed [lfu_pkg::KEY_W-1:0]  evicted_key;

	cache_scoreboard                   sb;
	int unsigned                       burst_left = 0;
	int unsigned                       stall_left = 0;
	logic                              stall_phase = 1'b1;
	logic signed [lfu_pkg::KEY_W-1:0]  key_pool [POOL_SIZE];
	logic [lfu_pkg::CAP_W-1:0]         phase_caps [6] = '{5'd2, 5'd31, 5'd0, 5'd1, 5'd7, 5'd16};

	lfu_cache_table_top #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

	always #5 clk = ~clk;

	// The result side alternates stall runs with free runs, some of them long.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_phase = !stall_phase;
			if (stall_phase) begin
				stall_left = $urandom_range(1, 15);
			end else if ($urandom_range(0, 9) < 3) begin
				stall_left = $urandom_range(20, 60);
			end else begin
				stall_left = $urandom_range(1, 8);
			end
		end
		stall_left--;
		out_stall <= stall_phase;
	end

	// Watch both handshakes at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_response({found, read_value, evicted, evicted_key});
			end
			if (in_valid && !in_stall) begin
				sb.apply_request({req_type, key, value});
			end
		end
	end

	function automatic cache_req_t make_req(logic kind, logic [lfu_pkg::KEY_W-1:0] k,
			logic [lfu_pkg::VAL_W-1:0] v);
		cache_req_t r;
		r.req_type = kind;
		r.key = k;
		r.value = v;
		return r;
	endfunction

	// Present one request, opening a new burst after a random gap when the last one ran out.
	task automatic send_request(input cache_req_t r);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= r.req_type;
		key <= r.key;
		value <= r.value;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and let every outstanding request come back before the block is touched.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.due_responses.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.capacity = cap;
	endtask

	// Pool keys are picked with a bias toward the low indexes so use counts spread out.
	task automatic random_phase(input logic [lfu_pkg::CAP_W-1:0] cap);
		logic [lfu_pkg::KEY_W-1:0] k;
		write_capacity(cap);
		repeat (PHASE_REQS) begin
			if ($urandom_range(0, 99) < 85) begin
				k = key_pool[$urandom_range(0, $urandom_range(0, POOL_SIZE - 1))];
			end else begin
				k = $urandom;
			end
			send_request(make_req($urandom_range(0, 1) ? lfu_pkg::REQ_PUT : lfu_pkg::REQ_GET,
				k, $urandom));
		end
		wait_idle();
	endtask

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("lfu_cache_table_top regression: fail");
		$finish;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		req_type = lfu_pkg::REQ_GET;
		key = '0;
		value = '0;
		key_pool[0] = 32'sh7fffffff;
		key_pool[1] = 32'sh80000000;
		key_pool[2] = -32'sd1;
		key_pool[3] = '0;
		for (int j = 4; j < POOL_SIZE; j++) begin
			key_pool[j] = $urandom;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: a four-entry cache with extreme keys and values.
		write_capacity(5'd4);
		send_request(make_req(lfu_pkg::REQ_GET, '0, 32'h5a5a5a5a));     // miss on empty cache
		send_request(make_req(lfu_pkg::REQ_PUT, 32'h7fffffff, 32'h80000000));
		send_request(make_req(lfu_pkg::REQ_PUT, 32'h80000000, 32'h7fffffff));
		send_request(make_req(lfu_pkg::REQ_PUT, 32'hffffffff, 32'hffffffff));
		send_request(make_req(lfu_pkg::REQ_PUT, '0, '0));               // cache now full
		send_request(make_req(lfu_pkg::REQ_GET, 32'h7fffffff, '0));     // hit
		send_request(make_req(lfu_pkg::REQ_PUT, 32'h80000000, 32'h5555aaaa)); // update in place
		// Enough hits to drive one use count past its maximum.
		repeat (COUNT_MAX) begin
			send_request(make_req(lfu_pkg::REQ_GET, 32'hffffffff, 32'hffffffff));
		end
		// The put below evicts the lone low count.
		send_request(make_req(lfu_pkg::REQ_PUT, 32'h12345678, 32'h0f0f0f0f));
		send_request(make_req(lfu_pkg::REQ_GET, 32'h12345678, '0));
		// The put below evicts by recency among equal counts.
		send_request(make_req(lfu_pkg::REQ_PUT, 32'h0badcafe, 32'hf0f0f0f0));
		wait_idle();

		// Random phases: shrinking below occupancy, out of range, zero, one and back up.
		foreach (phase_caps[p]) begin
			random_phase(phase_caps[p]);
		end

		if (sb.mismatches == 0 && sb.due_responses.size() == 0) begin
			$display("lfu_cache_table_top regression: pass");
		end else begin
			$display("lfu_cache_table_top regression: fail");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/lfu_pkg.sv
rtl/lfu_dp.sv
rtl/lfu_ctrl.sv
rtl/lfu_cache_table_top.sv
dv/tb_lfu_cache_table_top.sv
